[rtl/biquad_iir_filter_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define BQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define BQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/bq_pkg.sv]
package bq_pkg;

  localparam int COEF_W    = 32;  // Q4.28 coefficients
  localparam int Q_W       = 48;  // Q32.16 internal values
  localparam int ACC_W     = 56;  // sum of five rounded products
  localparam int MREG_W    = 65;  // 32 x 33 signed product
  localparam int PROD_W    = 80;  // full coefficient * Q32.16 product
  localparam int REG_IDX_W = 3;
  localparam int NUM_STEPS = 20;
  localparam int PC_W      = 5;

  // Register indexes, also used as coefficient select in microcode.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_INV_A0, REG_OUT_SCALE
  } bq_reg_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
  } bq_seq_t;

  typedef enum logic [2:0] {
    OPND_X, OPND_X1, OPND_X2, OPND_Y1, OPND_Y2, OPND_ACC, OPND_W
  } bq_opnd_t;

  typedef enum logic [1:0] {
    PA_NONE, PA_LOAD, PA_ADD
  } bq_pa_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_ACC_LOAD, DST_ACC_ADD, DST_ACC_SUB, DST_ACC_SAT, DST_W, DST_OUT
  } bq_dst_t;

  // One microcode word.
  typedef struct packed {
    bq_seq_t  seq;
    bq_reg_t  coef;
    bq_opnd_t opnd;
    logic     mul_hi;    // multiply by upper 32 bits of operand
    bq_pa_t   pa;
    logic     pa_hi;     // product in mreg came from the upper half
    bq_dst_t  dst;
    logic     rnd_long;  // round by 2^44 instead of 2^28
  } bq_ctrl_t;

  typedef struct packed {
    logic take;    // input transaction this cycle
    logic commit;  // result handed to output register, history advances
  } bq_evt_t;

endpackage

[rtl/bq_seq.sv]
module bq_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output bq_pkg::bq_ctrl_t ctrl,
  output bq_pkg::bq_evt_t  evt
);
  import bq_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            out_free;

  // Microprogram: multiply -> product accumulate -> round, overlapped.
  function automatic bq_ctrl_t rom(input logic [PC_W-1:0] a);
    bq_ctrl_t w;
    w = '0;
    case (a)
      PC_W'(0):  w.seq = SEQ_WAIT_IN;
      PC_W'(1):  begin w.coef = REG_B0; w.opnd = OPND_X; w.mul_hi = 1'b1; end
      PC_W'(2):  begin
        w.coef = REG_B1; w.opnd = OPND_X1; w.mul_hi = 1'b1;
        w.pa = PA_LOAD; w.pa_hi = 1'b1;
      end
      PC_W'(3):  begin
        w.coef = REG_B2; w.opnd = OPND_X2; w.mul_hi = 1'b1;
        w.pa = PA_LOAD; w.pa_hi = 1'b1; w.dst = DST_ACC_LOAD;
      end
      PC_W'(4):  begin
        w.coef = REG_A1; w.opnd = OPND_Y1;
        w.pa = PA_LOAD; w.pa_hi = 1'b1; w.dst = DST_ACC_ADD;
      end
      PC_W'(5):  begin
        w.coef = REG_A1; w.opnd = OPND_Y1; w.mul_hi = 1'b1;
        w.pa = PA_LOAD; w.dst = DST_ACC_ADD;
      end
      PC_W'(6):  begin
        w.coef = REG_A2; w.opnd = OPND_Y2;
        w.pa = PA_ADD; w.pa_hi = 1'b1;
      end
      PC_W'(7):  begin
        w.coef = REG_A2; w.opnd = OPND_Y2; w.mul_hi = 1'b1;
        w.pa = PA_LOAD; w.dst = DST_ACC_SUB;
      end
      PC_W'(8):  begin w.pa = PA_ADD; w.pa_hi = 1'b1; end
      PC_W'(9):  w.dst = DST_ACC_SUB;
      PC_W'(10): w.dst = DST_ACC_SAT;
      PC_W'(11): begin w.coef = REG_INV_A0; w.opnd = OPND_ACC; end
      PC_W'(12): begin
        w.coef = REG_INV_A0; w.opnd = OPND_ACC; w.mul_hi = 1'b1; w.pa = PA_LOAD;
      end
      PC_W'(13): begin w.pa = PA_ADD; w.pa_hi = 1'b1; end
      PC_W'(14): w.dst = DST_W;
      PC_W'(15): begin w.coef = REG_OUT_SCALE; w.opnd = OPND_W; end
      PC_W'(16): begin
        w.coef = REG_OUT_SCALE; w.opnd = OPND_W; w.mul_hi = 1'b1; w.pa = PA_LOAD;
      end
      PC_W'(17): begin w.pa = PA_ADD; w.pa_hi = 1'b1; end
      PC_W'(18): begin w.dst = DST_OUT; w.rnd_long = 1'b1; end
      PC_W'(NUM_STEPS-1): w.seq = SEQ_WAIT_OUT;
      default:   w.seq = SEQ_WAIT_OUT;
    endcase
    return w;
  endfunction

  assign ctrl     = rom(pc);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctrl.seq)
      SEQ_WAIT_IN:  pc_next = in_valid ? pc + PC_W'(1) : pc;
      SEQ_WAIT_OUT: pc_next = out_free ? '0 : pc;
      default:      pc_next = pc + PC_W'(1);
    endcase
  end

  always_comb begin
    in_ready   = (ctrl.seq == SEQ_WAIT_IN);
    evt.take   = in_ready && in_valid;
    evt.commit = (ctrl.seq == SEQ_WAIT_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/bq_dp.sv]
module bq_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bq_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [bq_pkg::COEF_W-1:0]         cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  bq_pkg::bq_ctrl_t                  ctrl,
  input  bq_pkg::bq_evt_t                   evt,
  output logic signed [SAMPLE_BITS-1:0]     res_out,
  output logic                              res_clip
);
  import bq_pkg::*;

  localparam int XPAD = 32 - SAMPLE_BITS;
  localparam int OPAD = ACC_W - SAMPLE_BITS + 1;

  logic signed [COEF_W-1:0] b0, b1, b2, a1, a2, inv_a0, out_scale;
  logic signed [SAMPLE_BITS-1:0] x, x1, x2;
  logic signed [Q_W-1:0]   y1, y2, w;
  logic signed [ACC_W-1:0] acc;
  logic signed [MREG_W-1:0] mreg;
  logic signed [PROD_W-1:0] p;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [32:0]       mul_b;
  logic signed [Q_W-1:0]    opnd;
  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] p_rnd;
  logic signed [PROD_W-1:0] r_full;
  logic signed [ACC_W-1:0]  r;
  logic                     acc_ovf, r_ovf, o_ovf;
  logic signed [SAMPLE_BITS-1:0] o_sat;

  function automatic logic [Q_W-1:0] sext_x(input logic [SAMPLE_BITS-1:0] v);
    return {{XPAD{v[SAMPLE_BITS-1]}}, v, 16'b0};
  endfunction

  function automatic logic ovf48(input logic [ACC_W-1:0] v);
    return v[ACC_W-1:Q_W-1] != {(ACC_W-Q_W+1){v[Q_W-1]}};
  endfunction

  function automatic logic [Q_W-1:0] sat48(input logic [ACC_W-1:0] v);
    if (ovf48(v)) begin
      return v[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
    return v[Q_W-1:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b0        <= 32'sh1000_0000;
      b1        <= '0;
      b2        <= '0;
      a1        <= '0;
      a2        <= '0;
      inv_a0    <= 32'sh1000_0000;
      out_scale <= 32'sh1000_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:        b0        <= cfg_data;
        REG_B1:        b1        <= cfg_data;
        REG_B2:        b2        <= cfg_data;
        REG_A1:        a1        <= cfg_data;
        REG_A2:        a2        <= cfg_data;
        REG_INV_A0:    inv_a0    <= cfg_data;
        REG_OUT_SCALE: out_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection
  always_comb begin
    case (ctrl.coef)
      REG_B0:        mul_a = b0;
      REG_B1:        mul_a = b1;
      REG_B2:        mul_a = b2;
      REG_A1:        mul_a = a1;
      REG_A2:        mul_a = a2;
      REG_INV_A0:    mul_a = inv_a0;
      REG_OUT_SCALE: mul_a = out_scale;
      default:       mul_a = b0;
    endcase
    case (ctrl.opnd)
      OPND_X:   opnd = sext_x(x);
      OPND_X1:  opnd = sext_x(x1);
      OPND_X2:  opnd = sext_x(x2);
      OPND_Y1:  opnd = y1;
      OPND_Y2:  opnd = y2;
      OPND_ACC: opnd = acc[Q_W-1:0];
      OPND_W:   opnd = w;
      default:  opnd = w;
    endcase
    mul_b = ctrl.mul_hi ? {opnd[Q_W-1], opnd[Q_W-1:16]} : {17'b0, opnd[15:0]};
  end

  // Upper-half products stay within 64 bits, so the top sign bit is dropped.
  assign term = ctrl.pa_hi ? {mreg[63:0], 16'b0}
                           : {{(PROD_W-MREG_W){mreg[MREG_W-1]}}, mreg};

  // Round half up: floor((p + 2^(n-1)) / 2^n)
  always_comb begin
    p_rnd  = p + (ctrl.rnd_long ? (PROD_W'(1) <<< 43) : (PROD_W'(1) <<< 27));
    r_full = ctrl.rnd_long ? (p_rnd >>> 44) : (p_rnd >>> 28);
    r      = r_full[ACC_W-1:0];
  end

  assign acc_ovf = ovf48(acc);
  assign r_ovf   = ovf48(r);
  assign o_ovf   = r[ACC_W-1:SAMPLE_BITS-1] != {OPAD{r[SAMPLE_BITS-1]}};
  assign o_sat   = o_ovf ? (r[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}})
                         : r[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    mreg <= mul_a * mul_b;

    case (ctrl.pa)
      PA_LOAD: p <= term;
      PA_ADD:  p <= p + term;
      default: ;
    endcase

    if (evt.take) begin
      x        <= sample;
      res_clip <= 1'b0;
    end

    case (ctrl.dst)
      DST_ACC_LOAD: acc <= r;
      DST_ACC_ADD:  acc <= acc + r;
      DST_ACC_SUB:  acc <= acc - r;
      DST_ACC_SAT: begin
        acc <= {{(ACC_W-Q_W){1'b0}}, sat48(acc)};
        if (acc_ovf) res_clip <= 1'b1;
      end
      DST_W: begin
        w <= sat48(r);
        if (r_ovf) res_clip <= 1'b1;
      end
      DST_OUT: begin
        res_out <= o_sat;
        if (o_ovf) res_clip <= 1'b1;
      end
      default: ;
    endcase
  end

  // Sample and result history
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (evt.commit) begin
      x1 <= x;
      x2 <= x1;
      y1 <= w;
      y2 <= y1;
    end
  end

endmodule

[rtl/biquad_iir_filter.sv]
// Biquad direct-form-I section, one shared 32x33 multiplier under microcode.
// One sample in flight: a new sample is taken only after the last result
//   is committed; the 20-step program on the single multiplier / product
//   accumulator (11 partial multiplies + rounds) runs for each sample.
// Reset (synchronous, rst high): coefficients to defaults, history cleared,
//   output register empty; block is ready for input the next cycle.
`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port (no read-back)
  input  logic                          cfg_we,
  input  logic [bq_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [bq_pkg::COEF_W-1:0]     cfg_data,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic                          clipped
);
  import bq_pkg::*;

  bq_ctrl_t ctrl;
  bq_evt_t  evt;
  logic signed [SAMPLE_BITS-1:0] res_out;
  logic                          res_clip;

  // Sequencer: step counter + microcode ROM. It parks on the first step
  // until an input transaction arrives and on the last step until the
  // output register can take the result.
  bq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl),
    .evt       (evt)
  );

  // Datapath: coefficient registers, history, multiplier, 80-bit product
  // accumulator, rounding, 56-bit sum accumulator and saturation.
  bq_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .ctrl      (ctrl),
    .evt       (evt),
    .res_out   (res_out),
    .res_clip  (res_clip)
  );

  // Output register: holds a finished result so the sequencer can start the
  // next sample while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.commit) begin
      filtered <= res_out;
      clipped  <= res_clip;
    end
  end

  // A commit never overwrites a result the consumer has not taken.
  `BQ_ASSERT_IMPL(a_no_overwrite, clk, rst, evt.commit, (!out_valid || out_ready))
  // A committed result is presented next cycle.
  `BQ_ASSERT_NEXT(a_commit_shows, clk, rst, evt.commit, out_valid)
  // Once a sample is taken, no further input until it completes.
  `BQ_ASSERT_NEXT(a_one_in_flight, clk, rst, evt.take, !in_ready)
  // Take and commit sit on different program steps.
  `BQ_ASSERT_IMPL(a_take_commit_excl, clk, rst, evt.take, !evt.commit)

endmodule

[dv/biquad_iir_filter_test.sv]
`timescale 1ns / 1ps

module biquad_iir_filter_test;
  import bq_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int NUM_COEFS = 7;
  // cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT = 1000;
  // extra cycles run after the final drain before outstanding results are checked
  localparam int TAIL_CYCLES = 40;
  localparam int KEEP = -1;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = '1;

  localparam logic signed [COEF_W-1:0] ONE_Q28 = 32'sh1000_0000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COEF_W-1:0] coef_set_t [NUM_COEFS];

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } out_item_t;

  typedef struct packed {
    logic      pin;  // compare against the typed-in value, not the filter model
    out_item_t val;
  } pinned_t;

  // directed row: optional coefficient reload, then one sample
  typedef struct packed {
    int                         cfg;
    logic signed [SAMPLE_W-1:0] x;
    logic                       pin;
    logic signed [SAMPLE_W-1:0] want;
    logic                       want_clip;
  } step_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       clipped;

  biquad_iir_filter #(.SAMPLE_BITS(SAMPLE_W)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .filtered(filtered), .clipped(clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter model state: a mirror of the coefficient registers and the
  // direct-form-I history (x[n-1], x[n-2], w[n-1], w[n-2]).
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0]   coef_q28 [NUM_COEFS];
  logic signed [SAMPLE_W-1:0] past_x [2];
  logic signed [Q_W-1:0]      past_w [2];

  out_item_t expected_out [$];
  pinned_t   pinned_q [$];

  int  sent_count = 0;
  int  got_count = 0;
  int  mismatches = 0;
  int  clip_count = 0;
  int  settings_count = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  tx_bursty = 1'b1;
  bit  rx_bursty = 1'b1;

  // floor(c * y / 2^shift + 1/2)
  function automatic wide_t round_mul(input logic signed [COEF_W-1:0] c, input wide_t y,
                                      input int shift);
    wide_t cw, half;
    cw = wide_t'(c);
    half = wide_t'(1);
    half = half <<< (shift - 1);
    return (cw * y + half) >>> shift;
  endfunction

  function automatic wide_t clamp(input wide_t v, input int bits, inout bit hit);
    wide_t hi, lo;
    hi = wide_t'(1);
    hi = (hi <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One biquad step: rounded products summed, scaled by 1/a0, then by the
  // output gain straight to integer units. Any clamp along the way sets clip.
  function automatic out_item_t filter_step(input logic signed [SAMPLE_W-1:0] x);
    wide_t     x0, x1, x2, y1, y2, acc, w, o;
    bit        hit;
    out_item_t r;
    hit = 1'b0;
    x0 = wide_t'(x);
    x1 = wide_t'(past_x[0]);
    x2 = wide_t'(past_x[1]);
    y1 = wide_t'(past_w[0]);
    y2 = wide_t'(past_w[1]);
    acc = round_mul(coef_q28[REG_B0], x0 <<< 16, 28)
        + round_mul(coef_q28[REG_B1], x1 <<< 16, 28)
        + round_mul(coef_q28[REG_B2], x2 <<< 16, 28)
        - round_mul(coef_q28[REG_A1], y1, 28)
        - round_mul(coef_q28[REG_A2], y2, 28);
    acc = clamp(acc, Q_W, hit);
    w = clamp(round_mul(coef_q28[REG_INV_A0], acc, 28), Q_W, hit);
    o = clamp(round_mul(coef_q28[REG_OUT_SCALE], w, 44), SAMPLE_W, hit);
    past_x[1] = past_x[0];
    past_x[0] = x;
    past_w[1] = past_w[0];
    past_w[0] = w[Q_W-1:0];
    r.filtered = o[SAMPLE_W-1:0];
    r.clipped = hit;
    return r;
  endfunction

  // Input side monitor: tracks register writes and queues the expected
  // result of every accepted sample transaction.
  always @(posedge clk) begin
    out_item_t predicted;
    pinned_t   note;
    if (rst) begin
      coef_q28 = '{ONE_Q28, 0, 0, 0, 0, ONE_Q28, ONE_Q28};
      past_x = '{default: '0};
      past_w = '{default: '0};
    end else begin
      if (cfg_we && cfg_index <= REG_OUT_SCALE)
        coef_q28[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        predicted = filter_step(sample);
        note = '0;
        if (pinned_q.size() != 0)
          note = pinned_q.pop_front();
        expected_out.push_back(note.pin ? note.val : predicted);
      end
    end
  end

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s at result %0d: expected %0d, got %0d",
               what, got_count, want, got);
  endtask

  // Output side: every result transaction is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        flag_mismatch("unexpected result, filtered", 0, int'(filtered));
      end else begin
        want = expected_out.pop_front();
        if (filtered !== want.filtered)
          flag_mismatch("filtered", int'(want.filtered), int'(filtered));
        if (clipped !== want.clipped)
          flag_mismatch("clipped", int'(want.clipped), int'(clipped));
      end
      if (clipped === 1'b1)
        clip_count++;
      got_count++;
    end
  end

  // Receiver back-pressure: random stalls while rx_bursty is set.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_bursty && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One sample transaction, optionally preceded by a sender gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic pin,
                             input logic signed [SAMPLE_W-1:0] want, input logic want_clip);
    pinned_t note;
    if (tx_bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    note.pin = pin;
    note.val.filtered = want;
    note.val.clipped = want_clip;
    pinned_q.push_back(note);
    in_valid <= 1'b1;
    sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Sender holds off until every result is back; the block is idle after.
  task automatic drain();
    in_valid <= 1'b0;
    while (got_count != sent_count) @(posedge clk);
  endtask

  // All seven coefficients, then a write to the unused index that must be
  // ignored.
  task automatic load_coefs(input coef_set_t c);
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= bq_reg_t'(i);
      cfg_data <= c[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // wild: saturating extremes and raw bit patterns; otherwise values in
  // [-0.5, 0.5), so |a1| + |a2| <= 1
  function automatic logic signed [COEF_W-1:0] pick_coef(input bit wild);
    if (wild) begin
      case ($urandom_range(0, 5))
        0: return COEF_MAX;
        1: return COEF_MIN;
        2: return 0;
        3: return ONE_Q28;
        default: return $urandom;
      endcase
    end
    return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed part. Rows typed in with an expected value are checked against
  // that value; the others go through the filter model.
  // ---------------------------------------------------------------------------
  coef_set_t dir_sets [4];
  step_row_t dir_rows [25];

  initial begin
    // output gain at its maximum: full-scale inputs clip
    dir_sets[0] = '{ONE_Q28, 0, 0, 0, 0, ONE_Q28, COEF_MAX};
    // gain one half: rounding ties go toward +infinity
    dir_sets[1] = '{ONE_Q28, 0, 0, 0, 0, ONE_Q28, 32'sh0800_0000};
    // extremes everywhere; the feedback blows up and saturates sum and w
    dir_sets[2] = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN};
    // an ordinary low-pass-like section
    dir_sets[3] = '{32'sh0400_0000, 32'sh0800_0000, 32'sh0400_0000, 32'shF800_0000,
                    32'sh0200_0000, 32'sh0C00_0000, 32'sh1400_0000};

    dir_rows = '{
      // reset coefficients: identity filter
      '{KEEP, 16'sd0,      1'b1, 16'sd0,      1'b0},
      '{KEEP, 16'sd32767,  1'b1, 16'sd32767,  1'b0},
      '{KEEP, -16'sd32768, 1'b1, -16'sd32768, 1'b0},
      '{KEEP, -16'sd1,     1'b1, -16'sd1,     1'b0},
      '{KEEP, 16'sd1,      1'b1, 16'sd1,      1'b0},
      '{KEEP, 16'sh5555,   1'b1, 16'sh5555,   1'b0},
      '{KEEP, 16'shAAAA,   1'b1, 16'shAAAA,   1'b0},
      // output saturation
      '{0,    16'sd32767,  1'b1, 16'sd32767,  1'b1},
      '{KEEP, -16'sd32768, 1'b1, -16'sd32768, 1'b1},
      '{KEEP, 16'sd0,      1'b1, 16'sd0,      1'b0},
      '{KEEP, 16'sd4095,   1'b0, 16'sd0,      1'b0},
      // rounding of x / 2
      '{1,    16'sd1,      1'b1, 16'sd1,      1'b0},
      '{KEEP, -16'sd1,     1'b1, 16'sd0,      1'b0},
      '{KEEP, 16'sd3,      1'b1, 16'sd2,      1'b0},
      '{KEEP, -16'sd3,     1'b1, -16'sd1,     1'b0},
      '{KEEP, 16'sd32767,  1'b1, 16'sd16384,  1'b0},
      '{KEEP, -16'sd32768, 1'b1, -16'sd16384, 1'b0},
      // sum and result saturation through the feedback path
      '{2,    16'sd32767,  1'b0, 16'sd0,      1'b0},
      '{KEEP, -16'sd32768, 1'b0, 16'sd0,      1'b0},
      '{KEEP, 16'sd32767,  1'b0, 16'sd0,      1'b0},
      '{KEEP, 16'sd100,    1'b0, 16'sd0,      1'b0},
      '{KEEP, 16'sd0,      1'b0, 16'sd0,      1'b0},
      // general section starting from a saturated history
      '{3,    16'sd1000,   1'b0, 16'sd0,      1'b0},
      '{KEEP, -16'sd2000,  1'b0, 16'sd0,      1'b0},
      '{KEEP, 16'sd0,      1'b0, 16'sd0,      1'b0}
    };
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    coef_set_t c;
    bit        wild;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != KEEP) begin
        drain();
        load_coefs(dir_sets[dir_rows[i].cfg]);
      end
      send_sample(dir_rows[i].x, dir_rows[i].pin, dir_rows[i].want, dir_rows[i].want_clip);
    end

    // Random part: eight coefficient settings of 50 samples each. Each
    // setting starts from a drained pipeline. The last one runs with no
    // idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      wild = 1'($urandom_range(0, 1));
      foreach (c[k])
        c[k] = pick_coef(wild);
      if (!wild) begin
        c[REG_INV_A0] = ONE_Q28 + pick_coef(1'b0);
        c[REG_OUT_SCALE] = ONE_Q28 + pick_coef(1'b0);
      end
      load_coefs(c);
      tx_bursty = (ph < 7) && ($urandom_range(0, 3) != 0);
      rx_bursty = (ph < 7) && ($urandom_range(0, 3) != 0);
      repeat (50)
        send_sample(pick_sample(), 1'b0, '0, 1'b0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_out.size() != 0)
      flag_mismatch("results still outstanding", 0, expected_out.size());

    $display("Ran %0d samples under %0d coefficient settings (reset values too);",
             sent_count, settings_count);
    $display("%0d results clipped, %0d mismatches.", clip_count, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
